### hw/rtl/spherize_source_coordinate_core_macros.svh
// Assertion macros for the spherize source-coordinate core checker.
// Needs a clk and an active-low rst_n in the scope that uses them.
`ifndef SPHERIZE_SOURCE_COORDINATE_CORE_MACROS_SVH
`define SPHERIZE_SOURCE_COORDINATE_CORE_MACROS_SVH

// Check a property on every rising edge, abandoned while in reset
`define SSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included
`define SSC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/ssc_pkg.sv
// Shared types and constants for the spherize source-coordinate core.
// No dependencies; imported by every module of the block.
package ssc_pkg;

  // Geometry limits
  localparam logic [12:0] MAX_SIDE      = 13'd4096;
  localparam logic [13:0] RADIUS_FULL   = 14'd10000;
  localparam logic [24:0] RADIUS_SCALE2 = 25'd25000000;
  localparam logic signed [33:0] ONE_Q30 = 34'sh0_4000_0000;

  // Pipeline shape
  localparam int QUO_W        = 17;
  localparam int FRONT_STAGES = 5;
  localparam int MAP_STAGES   = 3;
  localparam int PIPE_LAT     = FRONT_STAGES + QUO_W + MAP_STAGES;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 3'd0,
    CFG_IMAGE_HEIGHT = 3'd1,
    CFG_BULGE_AMOUNT = 3'd2,
    CFG_RADIUS       = 3'd3
  } cfg_idx_t;

  // Register reset values
  localparam logic [12:0]        RST_IMAGE_WIDTH  = 13'd640;
  localparam logic [12:0]        RST_IMAGE_HEIGHT = 13'd480;
  localparam logic signed [15:0] RST_BULGE_AMOUNT = 16'sd8192;
  localparam logic [13:0]        RST_RADIUS       = 14'd5000;

  typedef struct packed {
    logic [11:0] dest_x;
    logic [11:0] dest_y;
  } in_item_t;

  typedef struct packed {
    logic [11:0] source_x;
    logic [11:0] source_y;
  } out_item_t;

  // One item on its way through the divider
  typedef struct packed {
    logic               vld;
    logic               in_rad;
    logic signed [13:0] ox;
    logic signed [13:0] oy;
    logic [51:0]        rem;
    logic [50:0]        den;
    logic [QUO_W-1:0]   quo;
  } div_t;

endpackage

### hw/rtl/spherize_source_coordinate_core.sv
// Top level of the spherize source-coordinate core: registers, front,
// divider chain and back stages. Depends on ssc_pkg and the ssc_* modules.
//
//   channel   ports                                  handshake
//   input     start, busy, in_item                   start & !busy
//   result    out_strobe, out_item                   out_strobe, one cycle
//   config    cfg_valid, cfg_ready, cfg_index, cfg_data  cfg_valid & cfg_ready
//
// One item enters per cycle while busy is low; each taken item passes 5 front
// stages, 17 divider stages and 3 back stages on its way to the result.
// The divider chain sets the depth: one quotient bit per stage.
// busy is high in reset and until rst_n is seen high; reset clears all valid
// bits and restores the register defaults.
// The result side cannot stall, so the pipeline never holds.
module spherize_source_coordinate_core
  import ssc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              in_item,
  output logic                  out_strobe,
  output out_item_t             out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [12:0]        width_r;
  logic [12:0]        height_r;
  logic signed [15:0] amount_r;
  logic [13:0]        radius_r;
  logic               busy_r;

  logic [12:0] side_w, side_h, side_m;
  logic [13:0] radius_cl;
  logic        in_take;
  div_t        chain [QUO_W+1];

  assign busy      = busy_r;
  assign cfg_ready = !busy_r;
  assign in_take   = start && !busy_r;

  // Hold busy through reset, clear it once rst_n is seen high
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_IMAGE_WIDTH;
      height_r <= RST_IMAGE_HEIGHT;
      amount_r <= RST_BULGE_AMOUNT;
      radius_r <= RST_RADIUS;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  width_r  <= cfg_data[12:0];
        CFG_IMAGE_HEIGHT: height_r <= cfg_data[12:0];
        CFG_BULGE_AMOUNT: amount_r <= $signed(cfg_data);
        CFG_RADIUS:       radius_r <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  // Clamp sides and radius to their working ranges
  assign side_w = (width_r == 13'd0) ? 13'd1 :
                  ((width_r > MAX_SIDE) ? MAX_SIDE : width_r);
  assign side_h = (height_r == 13'd0) ? 13'd1 :
                  ((height_r > MAX_SIDE) ? MAX_SIDE : height_r);
  assign side_m    = (side_w > side_h) ? side_w : side_h;
  assign radius_cl = (radius_r > RADIUS_FULL) ? RADIUS_FULL : radius_r;

  ssc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (in_take),
    .in_item (in_item),
    .side_w  (side_w),
    .side_h  (side_h),
    .side_m  (side_m),
    .radius  (radius_cl),
    .div_o   (chain[0])
  );

  // One quotient bit per stage
  for (genvar g = 0; g < QUO_W; g++) begin : g_div
    ssc_div_step u_step (
      .clk   (clk),
      .rst_n (rst_n),
      .div_i (chain[g]),
      .div_o (chain[g+1])
    );
  end

  ssc_map u_map (
    .clk        (clk),
    .rst_n      (rst_n),
    .div_i      (chain[QUO_W]),
    .side_w     (side_w),
    .side_h     (side_h),
    .amount     (amount_r),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

### hw/rtl/ssc_front.sv
// Front stages: half-pixel offsets, squared distance, squared radius and
// the inside test. Depends on ssc_pkg.
module ssc_front
  import ssc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  in_item_t    in_item,
  input  logic [12:0] side_w,
  input  logic [12:0] side_h,
  input  logic [12:0] side_m,
  input  logic [13:0] radius,
  output div_t        div_o
);

  logic               s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, s5_vld_r;
  logic signed [13:0] s1_ox_r, s1_oy_r, s2_ox_r, s2_oy_r;
  logic signed [13:0] s3_ox_r, s3_oy_r, s4_ox_r, s4_oy_r;
  logic signed [13:0] s5_ox_r, s5_oy_r;
  logic [25:0]        s1_rm_r;
  logic [25:0]        s2_sqx_r, s2_sqy_r;
  logic [50:0]        s2_q_r, s3_q_r, s4_q_r;
  logic [26:0]        s3_dsum_r;
  logic [51:0]        s4_dd_r;
  logic               s5_inside_r;
  logic [51:0]        s5_rem_r;
  logic [50:0]        s5_den_r;

  logic signed [13:0] ox_nxt, oy_nxt;
  logic [26:0]        rm_full;
  logic signed [27:0] sqx_full, sqy_full;
  logic [51:0]        q_full;
  logic [26:0]        dsum_nxt;
  logic [51:0]        dd_full;
  logic               inside_nxt;
  logic [50:0]        num_nxt;

  // Offsets from the centre in half pixels, radius in scaled units
  assign ox_nxt  = $signed({1'b0, in_item.dest_x, 1'b0}) - $signed({1'b0, side_w});
  assign oy_nxt  = $signed({1'b0, in_item.dest_y, 1'b0}) - $signed({1'b0, side_h});
  assign rm_full = {13'd0, radius} * {14'd0, side_m};

  // Squares
  assign sqx_full = s1_ox_r * s1_ox_r;
  assign sqy_full = s1_oy_r * s1_oy_r;
  assign q_full   = {26'd0, s1_rm_r} * {26'd0, s1_rm_r};

  // Distance sum, then scale to the radius units
  assign dsum_nxt = {1'b0, s2_sqx_r} + {1'b0, s2_sqy_r};
  assign dd_full  = {25'd0, s3_dsum_r} * {27'd0, RADIUS_SCALE2};

  // Inside test and division numerator
  assign inside_nxt = s4_dd_r < {1'b0, s4_q_r};
  assign num_nxt    = s4_q_r - s4_dd_r[50:0];

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
      s5_vld_r <= s4_vld_r;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    s1_ox_r     <= ox_nxt;
    s1_oy_r     <= oy_nxt;
    s1_rm_r     <= rm_full[25:0];
    s2_ox_r     <= s1_ox_r;
    s2_oy_r     <= s1_oy_r;
    s2_sqx_r    <= sqx_full[25:0];
    s2_sqy_r    <= sqy_full[25:0];
    s2_q_r      <= q_full[50:0];
    s3_ox_r     <= s2_ox_r;
    s3_oy_r     <= s2_oy_r;
    s3_dsum_r   <= dsum_nxt;
    s3_q_r      <= s2_q_r;
    s4_ox_r     <= s3_ox_r;
    s4_oy_r     <= s3_oy_r;
    s4_dd_r     <= dd_full;
    s4_q_r      <= s3_q_r;
    s5_ox_r     <= s4_ox_r;
    s5_oy_r     <= s4_oy_r;
    s5_inside_r <= inside_nxt;
    s5_rem_r    <= inside_nxt ? {1'b0, num_nxt} : 52'd0;
    s5_den_r    <= s4_q_r;
  end

  assign div_o.vld    = s5_vld_r;
  assign div_o.in_rad = s5_inside_r;
  assign div_o.ox     = s5_ox_r;
  assign div_o.oy     = s5_oy_r;
  assign div_o.rem    = s5_rem_r;
  assign div_o.den    = s5_den_r;
  assign div_o.quo    = '0;

endmodule

### hw/rtl/ssc_div_step.sv
// One restoring-division stage: compare, subtract, shift in a quotient bit.
// Depends on ssc_pkg.
module ssc_div_step
  import ssc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  div_t div_i,
  output div_t div_o
);

  logic        ge;
  logic [51:0] diff;
  logic [51:0] kept;
  div_t        step_nxt;
  logic        vld_r;
  div_t        pay_r;

  // Take the divisor out when it fits, then double the remainder
  assign ge   = div_i.rem >= {1'b0, div_i.den};
  assign diff = div_i.rem - {1'b0, div_i.den};
  assign kept = ge ? diff : div_i.rem;

  always_comb begin
    step_nxt     = div_i;
    step_nxt.rem = {kept[50:0], 1'b0};
    step_nxt.quo = {div_i.quo[QUO_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= div_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    pay_r <= step_nxt;
  end

  always_comb begin
    div_o     = pay_r;
    div_o.vld = vld_r;
  end

endmodule

### hw/rtl/ssc_map.sv
// Back stages: scale factor, offset products, truncation and clamping.
// Depends on ssc_pkg.
module ssc_map
  import ssc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  div_t               div_i,
  input  logic [12:0]        side_w,
  input  logic [12:0]        side_h,
  input  logic signed [15:0] amount,
  output logic               out_strobe,
  output out_item_t          out_item
);

  logic               m1_vld_r, m2_vld_r, m3_vld_r;
  logic signed [13:0] m1_ox_r, m1_oy_r;
  logic signed [33:0] m1_factor_r;
  logic signed [47:0] m2_px_r, m2_py_r;
  out_item_t          m3_item_r;

  logic signed [17:0] t_s;
  logic [33:0]        ta_full;
  logic signed [33:0] factor_nxt;
  logic [47:0]        px_full, py_full;
  out_item_t          item_nxt;

  // Centre plus scaled offset, truncated and clamped to the side
  function automatic logic [11:0] map_axis(input logic [12:0] side,
                                           input logic signed [47:0] p);
    logic signed [49:0] v;
    logic [17:0]        c;
    logic [12:0]        lim;
    v   = $signed({7'd0, side, 30'd0}) + $signed({{2{p[47]}}, p});
    c   = v[48:31];
    lim = side - 13'd1;
    if (v[49]) begin
      map_axis = 12'd0;
    end else if (c > {5'd0, lim}) begin
      map_axis = lim[11:0];
    end else begin
      map_axis = c[11:0];
    end
  endfunction

  // Factor in Q30: one plus (1 - d^2) times the amount inside the radius
  assign t_s        = $signed({1'b0, div_i.quo});
  assign ta_full    = {{16{t_s[17]}}, t_s} * {{18{amount[15]}}, amount};
  assign factor_nxt = div_i.in_rad ? (ONE_Q30 + $signed(ta_full)) : ONE_Q30;

  // Scaled offsets
  assign px_full = {{34{m1_ox_r[13]}}, m1_ox_r} * {{14{m1_factor_r[33]}}, m1_factor_r};
  assign py_full = {{34{m1_oy_r[13]}}, m1_oy_r} * {{14{m1_factor_r[33]}}, m1_factor_r};

  assign item_nxt.source_x = map_axis(side_w, m2_px_r);
  assign item_nxt.source_y = map_axis(side_h, m2_py_r);

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_vld_r <= 1'b0;
      m2_vld_r <= 1'b0;
      m3_vld_r <= 1'b0;
    end else begin
      m1_vld_r <= div_i.vld;
      m2_vld_r <= m1_vld_r;
      m3_vld_r <= m2_vld_r;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    m1_ox_r     <= div_i.ox;
    m1_oy_r     <= div_i.oy;
    m1_factor_r <= factor_nxt;
    m2_px_r     <= $signed(px_full);
    m2_py_r     <= $signed(py_full);
    m3_item_r   <= item_nxt;
  end

  assign out_strobe = m3_vld_r;
  assign out_item   = m3_item_r;

endmodule

### hw/rtl/ssc_checker.sv
// Port-level checker for the spherize source-coordinate core, with its bind.
// Depends on ssc_pkg and spherize_source_coordinate_core_macros.svh.
`include "spherize_source_coordinate_core_macros.svh"

module ssc_checker
  import ssc_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input in_item_t              in_item,
  input logic                  out_strobe,
  input out_item_t             out_item,
  input logic                  cfg_valid,
  input logic                  cfg_ready,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_data
);

  // Every taken item comes out after the fixed latency
  `SSC_ASSERT(a_item_out, (start && !busy) |-> ##PIPE_LAT out_strobe, "item lost")

  // No result without an item taken the fixed latency earlier
  `SSC_ASSERT(a_no_extra, out_strobe |-> $past(start && !busy, PIPE_LAT), "spurious result")

  // Busy is low once the busy register has seen reset released
  `SSC_ASSERT_ALWAYS(a_busy_low, (rst_n && $past(rst_n)) |-> !busy, "busy outside reset")

  // Config is refused exactly while busy
  `SSC_ASSERT(a_cfg_ready, cfg_ready != busy, "cfg_ready out of step with busy")

endmodule

bind spherize_source_coordinate_core ssc_checker u_ssc_checker (.*);

### tb/spherize_source_coordinate_core_tb.sv
// Self-checking testbench for the spherize source-coordinate core: drives
// coordinates and register writes and checks each result against a predictor.
// Depends on ssc_pkg and the spherize_source_coordinate_core RTL.
module spherize_source_coordinate_core_tb;
  import ssc_pkg::*;

  localparam int    CYCLE_LIMIT   = 400000;
  localparam int    PHASES        = 12;
  localparam int    PHASE_ITEMS   = 160;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  in_item_t              in_item = '0;
  logic                  out_strobe;
  out_item_t             out_item;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Register copies as the block should hold them
  logic [12:0]        img_w = RST_IMAGE_WIDTH;
  logic [12:0]        img_h = RST_IMAGE_HEIGHT;
  logic signed [15:0] amount = RST_BULGE_AMOUNT;
  logic [13:0]        radius = RST_RADIUS;

  in_item_t  coord_q[$];
  out_item_t source_q[$];
  int        fails = 0;
  int        cycles = 0;
  int        idle_left = 0;
  bit        drain_hold = 1'b0;
  bit        calm = 1'b0;

  spherize_source_coordinate_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Zero and oversize sides fall back to the legal range
  function automatic int eff_side(logic [12:0] v);
    if (v == 0) return 1;
    if (v > MAX_SIDE) return int'(MAX_SIDE);
    return int'(v);
  endfunction

  // Truncate the Q31 position toward zero and clamp it to the image
  function automatic logic [11:0] clamp_axis(longint side, longint off, longint fac);
    longint v;
    longint c;
    v = side * longint'(ONE_Q30) + off * fac;
    if (v < 0) return '0;
    c = v >>> 31;
    if (c > side - 1) c = side - 1;
    return c[11:0];
  endfunction

  // Source pixel for one destination pixel under the current registers
  function automatic out_item_t spherize_source(in_item_t it);
    longint     sw, sh, ox, oy, big, rm, q, d, t, fac;
    logic [127:0] num;
    out_item_t  res;
    sw  = eff_side(img_w);
    sh  = eff_side(img_h);
    ox  = 2 * longint'(it.dest_x) - sw;
    oy  = 2 * longint'(it.dest_y) - sh;
    big = (sw > sh) ? sw : sh;
    rm  = ((radius > RADIUS_FULL) ? longint'(RADIUS_FULL) : longint'(radius)) * big;
    q   = rm * rm;
    d   = (ox * ox + oy * oy) * longint'(RADIUS_SCALE2);
    fac = longint'(ONE_Q30);
    // Inside the radius: scale by 1 + (1 - d^2) * amount, 1 - d^2 in Q16
    if (d < q) begin
      num = 128'(q - d) << 16;
      t   = longint'(num / 128'(q));
      fac = fac + t * longint'(amount);
    end
    res.source_x = clamp_axis(sw, ox, fac);
    res.source_y = clamp_axis(sh, oy, fac);
    return res;
  endfunction

  function automatic in_item_t random_point();
    int       sw, sh, kx, ky;
    in_item_t it;
    sw = eff_side(img_w);
    sh = eff_side(img_h);
    kx = sw / 8 + 1;
    ky = sh / 8 + 1;
    case ($urandom_range(0, 9))
      0, 1: begin
        it.dest_x = 12'($urandom);
        it.dest_y = 12'($urandom);
      end
      2, 3, 4: begin
        it.dest_x = 12'(sw / 2 + int'($urandom_range(0, 2 * kx)) - kx);
        it.dest_y = 12'(sh / 2 + int'($urandom_range(0, 2 * ky)) - ky);
      end
      default: begin
        it.dest_x = 12'($urandom_range(0, sw - 1));
        it.dest_y = 12'($urandom_range(0, sh - 1));
      end
    endcase
    return it;
  endfunction

  task automatic queue_point(input int x, input int y);
    in_item_t it;
    it.dest_x = 12'(x);
    it.dest_y = 12'(y);
    coord_q.push_back(it);
  endtask

  // Write one register and mirror it once the write is taken
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_IMAGE_WIDTH:  img_w  = data[12:0];
      CFG_IMAGE_HEIGHT: img_h  = data[12:0];
      CFG_BULGE_AMOUNT: amount = data;
      CFG_RADIUS:       radius = data[13:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input int w, input int h, input int a, input int r);
    write_reg(CFG_IMAGE_WIDTH, 16'(w));
    write_reg(CFG_IMAGE_HEIGHT, 16'(h));
    write_reg(CFG_BULGE_AMOUNT, 16'(a));
    write_reg(CFG_RADIUS, 16'(r));
  endtask

  // Hold until every queued item is taken and every result is back;
  // look on the falling edge so the driver's updates have settled
  task automatic wait_drained();
    while (coord_q.size() != 0 || start || source_q.size() != 0) @(negedge clk);
  endtask

  // Driver: feed items from the queue, with idle bursts and drain pauses
  always @(posedge clk) begin : drive_items
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (start) source_q.push_back(spherize_source(in_item));
      if (drain_hold && source_q.size() == 0) drain_hold = 1'b0;
      if (!calm && idle_left == 0 && $urandom_range(0, 15) == 0)
        idle_left = $urandom_range(1, 17);
      if (!calm && !drain_hold && $urandom_range(0, 399) == 0) drain_hold = 1'b1;
      if (idle_left > 0) begin
        idle_left = idle_left - 1;
        start <= 1'b0;
      end else if (drain_hold || coord_q.size() == 0) begin
        start <= 1'b0;
      end else begin
        start   <= 1'b1;
        in_item <= coord_q.pop_front();
      end
    end
  end

  // Monitor: compare each result with the oldest prediction
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_strobe) begin
      if (source_q.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d", $time,
                 out_item.source_x, out_item.source_y);
        fails = fails + 1;
      end else begin
        want = source_q.pop_front();
        if (out_item.source_x !== want.source_x) begin
          $display("%0t: source_x expected %0d, got %0d", $time,
                   want.source_x, out_item.source_x);
          fails = fails + 1;
        end
        if (out_item.source_y !== want.source_y) begin
          $display("%0t: source_y expected %0d, got %0d", $time,
                   want.source_y, out_item.source_y);
          fails = fails + 1;
        end
      end
    end
  end

  // Abandon a run that hangs
  always @(posedge clk) begin : watchdog
    cycles = cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("spherize_source_coordinate_core_tb: FAIL");
      $finish;
    end
  end

  initial begin : run_phases
    int sw, sh;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed points under the reset registers: corners, centre, rim, outside
    queue_point(0, 0);       queue_point(4095, 4095); queue_point(0, 4095);
    queue_point(4095, 0);    queue_point(320, 240);   queue_point(319, 239);
    queue_point(321, 241);   queue_point(639, 479);   queue_point(640, 480);
    queue_point(2047, 2048); queue_point(2730, 1365); queue_point(1365, 2730);
    queue_point(320, 0);     queue_point(0, 240);     queue_point(480, 240);
    queue_point(320, 400);   queue_point(100, 100);   queue_point(500, 400);
    queue_point(1, 1);       queue_point(638, 478);

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      if (p == PHASES - 1) calm = 1'b1;
      case (p)
        0: ;
        1: begin
          write_all(4096, 4096, 16384, 10000);
          write_reg(CFG_SPARE_IDX, 16'($urandom));
        end
        2: write_all(1, 1, -16384, 10000);
        3: write_all(0, 8191, -32768, 16383);
        4: write_all(4097, 0, 32767, 0);
        5: write_all(33, 17, 0, 1);
        6: write_all(4096, 3, -16384, 7000);
        default: begin
          write_all(($urandom_range(0, 7) == 0) ? $urandom_range(1, 16)
                                                : $urandom_range(1, 4096),
                    ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16)
                                                : $urandom_range(1, 4096),
                    int'($urandom_range(0, 32768)) - 16384,
                    $urandom_range(0, 10000));
        end
      endcase
      sw = eff_side(img_w);
      sh = eff_side(img_h);
      queue_point(0, 0);
      queue_point(sw - 1, sh - 1);
      queue_point(sw / 2, sh / 2);
      queue_point(4095, 4095);
      repeat (PHASE_ITEMS) coord_q.push_back(random_point());
    end

    // Let the pipeline empty, then allow for any stray result
    wait_drained();
    repeat (PIPE_LAT + 8) @(posedge clk);
    if (fails == 0) begin
      $display("spherize_source_coordinate_core_tb: PASS");
    end else begin
      $display("spherize_source_coordinate_core_tb: FAIL");
    end
    $finish;
  end

endmodule

### spherize_source_coordinate_core.f
+incdir+hw/rtl
hw/rtl/ssc_pkg.sv
hw/rtl/ssc_front.sv
hw/rtl/ssc_div_step.sv
hw/rtl/ssc_map.sv
hw/rtl/spherize_source_coordinate_core.sv
hw/rtl/ssc_checker.sv
tb/spherize_source_coordinate_core_tb.sv
